// ===== design/bpbc_pkg.sv =====
// package for the bit permutation block cipher
// shared operation codes and configuration indices; no dependencies
`timescale 1ns / 1ps
package bpbc_pkg;
    localparam logic [1:0] OP_KEY   = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam logic       CFG_BITS = 1'b0;
    localparam logic       CFG_MODE = 1'b1;
endpackage

// ===== design/bpbc_ram.sv =====
// generic single port synchronous ram with registered read
// no dependencies
`timescale 1ns / 1ps
module bpbc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== design/bit_permutation_block_cipher.sv =====
// top level of the bit permutation block cipher
// uses bpbc_pkg and bpbc_ram for key, block and result storage
`timescale 1ns / 1ps
// Items are taken one at a time: start is accepted while busy is low, and busy stays high
// until the item is done. Key loads, the unused operation and a flush with nothing held go
// through S_DONE alone. A data byte that does not close a block passes S_BYTE, which writes
// its bits into the block memory, then S_DONE. A byte that closes an N bit block runs a
// clear of the whole result memory, the permutation (key read, then block read), the shift of
// the result out one bit a cycle, and the key evolution, all on one port per memory. A flush
// of A bits clears the result memory, compacts the key, then permutes and shifts out the A
// bits without key evolution. Result words come with o_valid for one cycle each and cannot
// be held off.
module bit_permutation_block_cipher #(
    parameter int MAX_BLOCK_BITS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [11:0] i_key_index,
    input  logic [12:0] i_key_value,
    input  logic [7:0]  i_data_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data,
    output logic        o_valid,
    output logic [63:0] o_out_bytes,
    output logic [3:0]  o_byte_count,
    output logic        o_last_of_block
);
    localparam int AW = $clog2(MAX_BLOCK_BITS);
    localparam int CW = AW + 1;
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001, S_BYTE = 9'b000000010, S_CLR = 9'b000000100,
        S_CMP  = 9'b000001000, S_PRM = 9'b000010000, S_EMT = 9'b000100000,
        S_EVA  = 9'b001000000, S_EVB = 9'b010000000, S_DONE = 9'b100000000
    } t_state;
    t_state r_st;
    logic [12:0] r_bits;
    logic r_dec, r_flush;
    logic [9:0] r_held;
    logic [7:0] r_byte;
    logic [2:0] r_bi;
    logic [CW-1:0] r_i, r_y, r_lim, r_n;
    logic [CW:0] r_ph;
    logic [63:0] r_acc;
    logic [11:0] r_cv;
    logic [CW-1:0] r_pi;
    logic r_pv;
    // memories
    logic cw_we, pw_we, nw_we, bw_we, qw_we;
    logic [AW-1:0] c_a, p_a, n_a, b_a, q_a;
    logic [11:0] c_wd, p_wd, n_wd, c_rd, p_rd, n_rd;
    logic b_wd, q_wd, b_rd, q_rd;
    bpbc_ram #(.WIDTH(12), .DEPTH(MAX_BLOCK_BITS)) u_cur (.i_clk, .i_we(cw_we),
        .i_addr(c_a), .i_wdata(c_wd), .o_rdata(c_rd));
    bpbc_ram #(.WIDTH(12), .DEPTH(MAX_BLOCK_BITS)) u_prv (.i_clk, .i_we(pw_we),
        .i_addr(p_a), .i_wdata(p_wd), .o_rdata(p_rd));
    bpbc_ram #(.WIDTH(12), .DEPTH(MAX_BLOCK_BITS)) u_nxt (.i_clk, .i_we(nw_we),
        .i_addr(n_a), .i_wdata(n_wd), .o_rdata(n_rd));
    bpbc_ram #(.WIDTH(1), .DEPTH(MAX_BLOCK_BITS)) u_blk (.i_clk, .i_we(bw_we),
        .i_addr(b_a), .i_wdata(b_wd), .o_rdata(b_rd));
    bpbc_ram #(.WIDTH(1), .DEPTH(MAX_BLOCK_BITS)) u_prm (.i_clk, .i_we(qw_we),
        .i_addr(q_a), .i_wdata(q_wd), .o_rdata(q_rd));

    logic [CW-1:0] eff;
    always_comb begin
        if (r_bits < 13'd64) eff = CW'(64);
        else if (r_bits > 13'(MAX_BLOCK_BITS)) eff = CW'(MAX_BLOCK_BITS);
        else eff = CW'(r_bits & 13'h1FC0);
    end

    assign busy = (r_st != S_IDLE);
    assign o_cfg_ready = (r_st == S_IDLE) && !start;
    logic acc_in;
    assign acc_in = start && !busy;

    // phase counter r_ph: its low bit splits each element into an even and an odd phase where a read must come back
    logic [CW-1:0] ph_i;
    logic ph_o;
    assign ph_i = r_ph[CW:1];
    assign ph_o = r_ph[0];
    logic [11:0] k_use;
    assign k_use = r_flush ? n_rd : c_rd;

    always_comb begin
        cw_we = 1'b0; pw_we = 1'b0; nw_we = 1'b0; bw_we = 1'b0; qw_we = 1'b0;
        c_a = '0; p_a = '0; n_a = '0; b_a = '0; q_a = '0;
        c_wd = '0; p_wd = '0; n_wd = '0; b_wd = 1'b0; q_wd = 1'b0;
        unique case (r_st)
            S_IDLE: if (acc_in && i_operation == bpbc_pkg::OP_KEY
                        && 13'(i_key_index) < 13'(MAX_BLOCK_BITS)) begin
                cw_we = 1'b1; pw_we = 1'b1;
                c_a = AW'(i_key_index); p_a = AW'(i_key_index);
                c_wd = 12'(i_key_value - 13'd1); p_wd = c_wd;
            end
            S_BYTE: begin
                bw_we = 1'b1;
                b_a = AW'(13'(r_held) * 13'd8 + 13'(r_bi));
                b_wd = r_byte[3'd7 - r_bi];
            end
            S_CLR: begin
                qw_we = 1'b1; q_a = AW'(r_i);
            end
            S_CMP: begin
                c_a = AW'(ph_i);
                if (!ph_o && r_pv) begin
                    nw_we = 1'b1; n_a = AW'(r_y); n_wd = r_cv;
                end
            end
            S_PRM: begin
                // even: read key and write the previous block bit; odd: read block at source
                c_a = AW'(ph_i); n_a = AW'(ph_i);
                if (ph_o) begin
                    b_a = r_dec ? AW'(ph_i) : AW'(k_use);
                end
            end
            S_EMT: q_a = AW'(r_i);
            S_EVA: begin
                p_a = AW'(ph_i);
                c_a = AW'(p_rd);
                if (ph_o) begin
                    nw_we = 1'b1; n_a = AW'(ph_i - CW'(1));
                    n_wd = (13'(p_rd) < 13'(MAX_BLOCK_BITS)) ? c_rd : 12'd0;
                end
                p_a = ph_o ? AW'(ph_i) : AW'(ph_i);
                c_a = AW'(p_rd);
            end
            S_EVB: begin
                c_a = AW'(ph_i); n_a = AW'(ph_i); p_a = AW'(ph_i);
                if (ph_o) begin
                    cw_we = 1'b1; c_wd = n_rd; pw_we = 1'b1; p_wd = c_rd;
                end
            end
            default: ;
        endcase
        // permutation write
        if (r_st == S_PRM && r_pv) begin
            qw_we = 1'b1; q_a = AW'(r_pi); q_wd = b_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        o_valid <= 1'b0;
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_bits <= 13'd4096; r_dec <= 1'b0; r_held <= '0;
            r_pv <= 1'b0;
        end else begin
            unique case (r_st)
                S_IDLE: begin
                    if (i_cfg_valid && o_cfg_ready) begin
                        if (i_cfg_index == bpbc_pkg::CFG_BITS) begin
                            r_bits <= i_cfg_data; r_held <= '0;
                        end else r_dec <= i_cfg_data[0];
                    end
                    if (acc_in) begin
                        r_byte <= i_data_byte; r_bi <= '0; r_i <= '0; r_ph <= '0;
                        r_y <= '0; r_pv <= 1'b0; r_n <= eff;
                        if (i_operation == bpbc_pkg::OP_DATA) begin
                            if (13'(r_held) * 13'd8 + 13'd8 > 13'(eff)) r_held <= '0;
                            r_st <= S_BYTE;
                        end else if (i_operation == bpbc_pkg::OP_FLUSH && r_held != 0)
                        begin
                            r_flush <= 1'b1; r_lim <= CW'(13'(r_held) * 13'd8);
                            r_st <= S_CLR;
                        end else r_st <= S_DONE;
                    end
                end
                S_BYTE: begin
                    r_bi <= r_bi + 3'd1;
                    if (r_bi == 3'd7) begin
                        r_held <= r_held + 10'd1;
                        if ((13'(r_held) + 13'd1) * 13'd8 >= 13'(r_n)) begin
                            r_flush <= 1'b0; r_lim <= r_n; r_st <= S_CLR;
                        end else r_st <= S_DONE;
                    end
                end
                S_CLR: begin
                    r_i <= r_i + CW'(1);
                    if (r_i == CW'(MAX_BLOCK_BITS - 1)) begin
                        r_i <= '0; r_ph <= '0;
                        r_st <= r_flush ? S_CMP : S_PRM;
                    end
                end
                S_CMP: begin
                    r_ph <= r_ph + (CW+1)'(1);
                    r_pv <= 1'b0;
                    if (!ph_o) begin
                        if (r_pv) r_y <= r_y + CW'(1);
                    end else begin
                        r_cv <= c_rd;
                        r_pv <= (13'(c_rd) < 13'(r_lim)) && (r_y < r_lim);
                    end
                    if (ph_o && ph_i == r_n) begin
                        r_ph <= '0; r_pv <= 1'b0; r_st <= S_PRM;
                    end
                    if (ph_i > r_n) begin
                        r_ph <= '0; r_pv <= 1'b0; r_st <= S_PRM;
                    end
                end
                S_PRM: begin
                    r_ph <= r_ph + (CW+1)'(1);
                    r_pv <= 1'b0;
                    if (ph_o) begin
                        r_pv <= (13'(k_use) < 13'(r_lim))
                                && (!r_flush || ph_i < r_y) && ph_i < r_lim;
                        r_pi <= r_dec ? CW'(k_use) : ph_i;
                    end
                    if (ph_o && ph_i == r_lim) begin
                        r_st <= S_EMT; r_i <= '0; r_acc <= '0;
                    end
                end
                S_EMT: begin
                    r_pv <= 1'b0;
                    r_i <= r_i + CW'(1);
                    if (r_i != 0) r_acc <= {r_acc[62:0], q_rd};
                    if (r_i != 0 && (r_i[5:0] == 6'd0 || r_i == r_lim)) begin
                        o_valid <= 1'b1;
                        o_out_bytes <= {r_acc[62:0], q_rd};
                        o_byte_count <= (r_i[5:0] == 6'd0) ? 4'd8 : 4'({1'b0, r_i[5:3]});
                        o_last_of_block <= (r_i == r_lim);
                        r_acc <= '0;
                    end
                    if (r_i == r_lim) begin
                        r_ph <= '0;
                        r_held <= '0;
                        r_st <= r_flush ? S_DONE : S_EVA;
                    end
                end
                S_EVA: begin
                    r_ph <= r_ph + (CW+1)'(1);
                    if (ph_o && ph_i == r_n) begin r_ph <= '0; r_st <= S_EVB; end
                end
                S_EVB: begin
                    r_ph <= r_ph + (CW+1)'(1);
                    if (ph_o && ph_i == r_n - CW'(1)) r_st <= S_DONE;
                end
                S_DONE: r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
